@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define SLD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// condition must never be seen outside reset
`define SLD_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define SLD_ASSERT(lbl, clk, rstn, prop, msg)
`define SLD_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

@@ design/sldre_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sldre_pkg
// Types and constants of the screen line diff run emitter.
// ----------------------------------------------------------------------------
package sldre_pkg;

  localparam int MaxColsDefault = 128;
  localparam int MaxRowsDefault = 64;

  localparam logic [15:0] BlankCell      = 16'h0020;
  localparam logic [7:0]  LineWidthReset = 8'd80;
  localparam logic [7:0]  RunCountMax    = 8'hFF;

  // operation codes on the input tuser
  localparam logic OpCompare = 1'b0;
  localparam logic OpClear   = 1'b1;

  typedef enum logic [1:0] {
    KindChar  = 2'd0,
    KindEnd   = 2'd1,
    KindClear = 2'd2
  } kind_e;

  typedef struct packed {
    logic       last;
    kind_e      kind;
    logic [7:0] run_length;
    logic [7:0] run_mode;
    logic [5:0] out_row;
    logic [6:0] position;
    logic [7:0] char_code;
  } res_t;

endpackage

@@ design/screen_line_diff_run_emitter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// screen_line_diff_run_emitter_core
// Compares wanted screen cells with a stored character image, writes the
// changed cells back and reports them as runs of one attribute mode.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per cell: tuser = operation, tdata = row,
//   column, wanted cell, next wanted cell. Cells of a row come in column
//   order from 0. m_axis gives the results: tuser = kind, tlast marks the
//   final result of an input item. cfg_* writes line_width at any time the
//   block is idle; it is always ready.
//   Compare item: the accept cycle reads the cell and its right neighbor
//   from the two read ports of the image memory, then the evaluate state
//   decides, writes the cell back and queues up to three results.
//   Clear item: one write per image entry, then the clear done result.
//   Reset: the image is blanked by the same sweep, with s_axis_tready low
//   throughout.
//   Results wait in a four-entry queue; a new item is taken while results
//   are pending as long as three slots stay free. A stalled receiver fills
//   the queue and then holds s_axis_tready low; nothing is dropped.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module screen_line_diff_run_emitter_core #(
  parameter int MAX_COLS = sldre_pkg::MaxColsDefault,
  parameter int MAX_ROWS = sldre_pkg::MaxRowsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: line_width
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // row[5:0], column[12:6], wanted_cell[28:13],
                                     // next_wanted_cell[44:29], zero fill
  input  logic [0:0]  s_axis_tuser,  // operation[0]
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // char_code[7:0], position[14:8], out_row[20:15],
                                     // run_mode[28:21], run_length[36:29], zero fill
  output logic [1:0]  m_axis_tuser,  // kind[1:0]
  output logic        m_axis_tlast
);

  localparam int Depth    = MAX_ROWS * MAX_COLS;
  localparam int AddrW    = $clog2(Depth);
  localparam int ProdW    = 6 + $clog2(MAX_COLS) + 1;
  localparam int CmpW     = ($clog2(MAX_COLS + 1) > 8) ? $clog2(MAX_COLS + 1) : 8;
  localparam int RowCmpW  = ($clog2(MAX_ROWS + 1) > 6) ? $clog2(MAX_ROWS + 1) : 6;
  localparam int QDepth   = 4;
  localparam int QCntW    = 3;

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_EVAL,
    S_CLEAR
  } state_e;

  // --------------------------------------------------------------------------
  // input unpack
  // --------------------------------------------------------------------------
  logic        in_op;
  logic [5:0]  in_row;
  logic [6:0]  in_col;
  logic [15:0] in_cell;
  logic [15:0] in_next;
  logic        in_accept;

  assign in_op   = s_axis_tuser[0];
  assign in_row  = s_axis_tdata[5:0];
  assign in_col  = s_axis_tdata[12:6];
  assign in_cell = s_axis_tdata[28:13];
  assign in_next = s_axis_tdata[44:29];

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  state_e            state_q, state_d;
  logic [AddrW-1:0]  sweep_q, sweep_d;
  logic [7:0]        line_width_q;
  logic              run_open_q, run_open_d;
  logic [6:0]        run_start_q, run_start_d;
  logic [7:0]        run_mode_q, run_mode_d;
  logic [7:0]        run_cnt_q, run_cnt_d;
  logic [QCntW-1:0]  q_cnt_q, q_cnt_d;
  sldre_pkg::res_t   q_q [QDepth];
  sldre_pkg::res_t   q_d [QDepth];

  logic [5:0]        item_row_q;
  logic [6:0]        item_col_q;
  logic [15:0]       item_cell_q;
  logic [15:0]       item_next_q;
  logic [AddrW-1:0]  item_addr_q;

  // --------------------------------------------------------------------------
  // image memory: one write port, two read ports, registered read data
  // --------------------------------------------------------------------------
  logic [15:0]       mem [Depth];
  logic [15:0]       rd_cur_q, rd_nxt_q;
  logic [ProdW-1:0]  in_addr_full;
  logic [AddrW-1:0]  rd_addr, rd_addr_nxt;
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [15:0]       mem_wdata;

  assign in_addr_full = ProdW'(in_row) * ProdW'(MAX_COLS) + ProdW'(in_col);
  assign rd_addr      = AddrW'(in_addr_full);
  assign rd_addr_nxt  = (rd_addr == AddrW'(Depth - 1)) ? '0 : rd_addr + AddrW'(1);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_cur_q <= mem[rd_addr];
    rd_nxt_q <= mem[rd_addr_nxt];
  end

  // --------------------------------------------------------------------------
  // cell evaluation
  // --------------------------------------------------------------------------
  logic [CmpW-1:0]   width_eff;
  logic              ignore;
  logic              open0;
  logic              at_end;
  logic              same;
  logic              ahead_same;
  logic              end_only;
  logic              write_path;
  logic              split;
  logic              start_new;
  logic [7:0]        new_mode;
  logic [6:0]        new_start;
  logic [7:0]        cnt_base;
  logic [7:0]        cnt_new;
  logic              sweep_last;
  logic              pop;
  sldre_pkg::res_t   end_old, end_new, char_res, clr_res;
  sldre_pkg::res_t   new_res [3];
  logic [1:0]        n_push;

  assign width_eff = (CmpW'(line_width_q) > CmpW'(MAX_COLS)) ? CmpW'(MAX_COLS)
                                                               : CmpW'(line_width_q);
  assign ignore = (CmpW'(item_col_q) >= width_eff) ||
                  (RowCmpW'(item_row_q) >= RowCmpW'(MAX_ROWS));
  assign open0      = run_open_q && (item_col_q != 7'd0);
  assign at_end     = (CmpW'(item_col_q) + CmpW'(1)) == width_eff;
  assign same       = item_cell_q == rd_cur_q;
  assign ahead_same = at_end || (item_next_q == rd_nxt_q);
  // an unchanged plain blank keeps the run alive when the next cell changes
  assign end_only   = same && open0 &&
                      ((item_cell_q != sldre_pkg::BlankCell) || ahead_same);
  assign write_path = !(same && !open0) && !end_only;
  assign new_mode   = item_cell_q[15:8];
  assign split      = open0 && (new_mode != run_mode_q);
  assign start_new  = !open0 || split;
  assign new_start  = start_new ? item_col_q : run_start_q;
  assign cnt_base   = start_new ? 8'd0 : run_cnt_q;
  assign cnt_new    = (cnt_base == sldre_pkg::RunCountMax) ? cnt_base : cnt_base + 8'd1;
  assign sweep_last = sweep_q == AddrW'(Depth - 1);

  always_comb begin
    end_old            = '0;
    end_old.kind       = sldre_pkg::KindEnd;
    end_old.position   = run_start_q;
    end_old.out_row    = item_row_q;
    end_old.run_mode   = run_mode_q;
    end_old.run_length = run_cnt_q;

    end_new            = '0;
    end_new.kind       = sldre_pkg::KindEnd;
    end_new.position   = new_start;
    end_new.out_row    = item_row_q;
    end_new.run_mode   = new_mode;
    end_new.run_length = cnt_new;

    char_res           = '0;
    char_res.kind      = sldre_pkg::KindChar;
    char_res.char_code = item_cell_q[7:0];
    char_res.position  = item_col_q;
    char_res.out_row   = item_row_q;
    char_res.run_mode  = new_mode;

    clr_res            = '0;
    clr_res.kind       = sldre_pkg::KindClear;
  end

  // result list of the current step, compacted from slot 0
  always_comb begin
    new_res[0] = clr_res;
    new_res[1] = clr_res;
    new_res[2] = clr_res;
    n_push     = 2'd0;
    if (state_q == S_CLEAR) begin
      n_push = sweep_last ? 2'd1 : 2'd0;
    end else if (state_q == S_EVAL && !ignore) begin
      if (end_only) begin
        new_res[0] = end_old;
        n_push     = 2'd1;
      end else if (write_path) begin
        new_res[0] = split ? end_old : char_res;
        new_res[1] = split ? char_res : end_new;
        new_res[2] = end_new;
        n_push     = 2'd1 + 2'(split) + 2'(at_end);
      end
    end
    for (int j = 0; j < 3; j++) begin
      new_res[j].last = (2'(j) == n_push - 2'd1);
    end
  end

  // --------------------------------------------------------------------------
  // result queue: slot 0 drives the output
  // --------------------------------------------------------------------------
  logic [QCntW-1:0] kept;
  logic [QCntW-1:0] slot_off;
  sldre_pkg::res_t  shifted [QDepth];

  assign m_axis_tvalid = q_cnt_q != '0;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign kept          = q_cnt_q - QCntW'(pop);
  assign m_axis_tdata  = {3'b000, q_q[0].run_length, q_q[0].run_mode, q_q[0].out_row,
                          q_q[0].position, q_q[0].char_code};
  assign m_axis_tuser  = q_q[0].kind;
  assign m_axis_tlast  = q_q[0].last;

  always_comb begin
    slot_off = '0;
    for (int i = 0; i < QDepth; i++) begin
      shifted[i] = pop ? q_q[(i + 1 < QDepth) ? i + 1 : i] : q_q[i];
    end
    for (int i = 0; i < QDepth; i++) begin
      slot_off = QCntW'(i) - kept;
      if (QCntW'(i) < kept) begin
        q_d[i] = shifted[i];
      end else if (slot_off < QCntW'(n_push)) begin
        q_d[i] = new_res[slot_off[1:0]];
      end else begin
        q_d[i] = q_q[i];
      end
    end
    q_cnt_d = kept + QCntW'(n_push);
  end

  // --------------------------------------------------------------------------
  // control
  // --------------------------------------------------------------------------
  assign s_axis_tready = (state_q == S_IDLE) && (q_cnt_q <= QCntW'(1));
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign mem_we    = (state_q == S_INIT) || (state_q == S_CLEAR) ||
                     (state_q == S_EVAL && !ignore && write_path);
  assign mem_waddr = (state_q == S_EVAL) ? item_addr_q : sweep_q;
  assign mem_wdata = (state_q == S_EVAL) ? item_cell_q : sldre_pkg::BlankCell;

  always_comb begin
    state_d     = state_q;
    sweep_d     = sweep_q;
    run_open_d  = run_open_q;
    run_start_d = run_start_q;
    run_mode_d  = run_mode_q;
    run_cnt_d   = run_cnt_q;
    unique case (state_q)
      S_INIT: begin
        sweep_d = sweep_q + AddrW'(1);
        if (sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          if (in_op == sldre_pkg::OpClear) begin
            state_d    = S_CLEAR;
            sweep_d    = '0;
            run_open_d = 1'b0;
          end else begin
            state_d = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        state_d = S_IDLE;
        if (!ignore) begin
          if (end_only) begin
            run_open_d = 1'b0;
          end else if (write_path) begin
            run_open_d  = !at_end;
            run_start_d = new_start;
            run_mode_d  = new_mode;
            run_cnt_d   = cnt_new;
          end else begin
            run_open_d = open0;
          end
        end
      end
      S_CLEAR: begin
        sweep_d = sweep_q + AddrW'(1);
        if (sweep_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      sweep_q      <= '0;
      line_width_q <= sldre_pkg::LineWidthReset;
      run_open_q   <= 1'b0;
      run_start_q  <= '0;
      run_mode_q   <= '0;
      run_cnt_q    <= '0;
      q_cnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      run_open_q  <= run_open_d;
      run_start_q <= run_start_d;
      run_mode_q  <= run_mode_d;
      run_cnt_q   <= run_cnt_d;
      q_cnt_q     <= q_cnt_d;
      if (cfg_valid_i && cfg_ready_o) begin
        line_width_q <= cfg_data_i;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDepth; i++) begin
      q_q[i] <= q_d[i];
    end
    if (in_accept) begin
      item_row_q  <= in_row;
      item_col_q  <= in_col;
      item_cell_q <= in_cell;
      item_next_q <= in_next;
      item_addr_q <= rd_addr;
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `SLD_ASSERT_NEVER(a_queue_overflow, clk_i, rst_ni, q_cnt_q > QCntW'(QDepth),
                    "result queue overflow")
  `SLD_ASSERT(a_eval_one_cycle, clk_i, rst_ni, (state_q == S_EVAL) |=> (state_q == S_IDLE),
              "compare step did not return to idle")
  `SLD_ASSERT(a_clear_starts_sweep, clk_i, rst_ni,
              (in_accept && in_op == sldre_pkg::OpClear) |=> (state_q == S_CLEAR),
              "clear item did not start the sweep")
  `SLD_ASSERT_NEVER(a_busy_ready, clk_i, rst_ni,
                    (state_q == S_INIT || state_q == S_CLEAR) && s_axis_tready,
                    "item accepted during sweep")
  `SLD_ASSERT(a_open_run_nonempty, clk_i, rst_ni, run_open_q |-> (run_cnt_q != 8'd0),
              "open run without characters")

endmodule

@@ test/tb_screen_line_diff_run_emitter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_screen_line_diff_run_emitter_core
// Drives wanted screen cells and clears into the diff run emitter and checks
// every run character, run end and clear done result against a shadow image
// and run tracker kept in the bench. Directed cases cover bridging blanks,
// mode changes, the last column, ignored columns, stale runs and count
// saturation; random row scans follow at several line widths, with random
// gaps and stalls on both streams and one long output stall.
// ----------------------------------------------------------------------------
module tb_screen_line_diff_run_emitter_core;

  localparam int Cols       = 128;
  localparam int Rows       = 64;
  localparam int QuietLimit = 50000;
  localparam int SettleCyc  = 8;
  localparam int HoldCyc    = 400;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;  // row, column, wanted_cell, next_wanted_cell, zero fill
  logic [0:0]  s_axis_tuser;  // operation
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;  // char_code, position, out_row, run_mode, run_length, fill
  logic [1:0]  m_axis_tuser;  // kind
  logic        m_axis_tlast;

  screen_line_diff_run_emitter_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // shadow of the block state
  logic [15:0] screen_img [0:Rows*Cols-1];
  bit          run_active;
  logic [6:0]  run_start;
  logic [7:0]  run_attr;
  logic [7:0]  run_len;
  logic [7:0]  cfg_width;

  sldre_pkg::res_t expected_q [$];

  int  errors;
  int  items_sent;
  int  clears_sent;
  int  results_seen;
  int  quiet;
  bit  idle_on;
  bit  hold_req;
  int  hold_left;
  int  stall_left;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  task automatic report_mismatch(input string msg);
    if (errors < 40) $display("MISMATCH at result %0d: %s", results_seen, msg);
    errors++;
  endtask

  // ---------------- prediction ----------------
  function automatic void add_result(input sldre_pkg::kind_e kind, input logic [7:0] ch,
                                     input logic [6:0] pos, input logic [5:0] row,
                                     input logic [7:0] mode, input logic [7:0] len);
    sldre_pkg::res_t r;
    r.last       = 1'b0;
    r.kind       = kind;
    r.char_code  = ch;
    r.position   = pos;
    r.out_row    = row;
    r.run_mode   = mode;
    r.run_length = len;
    expected_q.push_back(r);
  endfunction

  function automatic void open_run(input logic [6:0] col, input logic [7:0] mode);
    run_active = 1'b1;
    run_start  = col;
    run_attr   = mode;
    run_len    = 8'd0;
  endfunction

  function automatic void close_run(input logic [5:0] row);
    add_result(sldre_pkg::KindEnd, 8'd0, run_start, row, run_attr, run_len);
    run_active = 1'b0;
  endfunction

  function automatic void blank_screen();
    for (int i = 0; i < Rows * Cols; i++) screen_img[i] = sldre_pkg::BlankCell;
  endfunction

  function automatic void predict_item(input logic op, input logic [5:0] row,
                                       input logic [6:0] col, input logic [15:0] want,
                                       input logic [15:0] ahead);
    int  n0;
    int  width;
    int  base;
    bit  at_end;
    bit  ahead_eq;
    n0 = expected_q.size();
    if (op == sldre_pkg::OpClear) begin
      blank_screen();
      run_active = 1'b0;
      add_result(sldre_pkg::KindClear, 8'd0, 7'd0, 6'd0, 8'd0, 8'd0);
    end else begin
      width = (cfg_width > Cols) ? Cols : int'(cfg_width);
      if (int'(col) >= width) return;
      if (col == 7'd0) run_active = 1'b0;
      base   = int'(row) * Cols;
      at_end = (int'(col) + 1 == width);
      if (want == screen_img[base + col]) begin
        if (!run_active) return;
        ahead_eq = at_end ? 1'b1 : (ahead == screen_img[base + col + 1]);
        if (want != sldre_pkg::BlankCell || ahead_eq) begin
          close_run(row);
          expected_q[expected_q.size() - 1].last = 1'b1;
          return;
        end
      end
      if (!run_active) begin
        open_run(col, want[15:8]);
      end else if (want[15:8] != run_attr) begin
        close_run(row);
        open_run(col, want[15:8]);
      end
      add_result(sldre_pkg::KindChar, want[7:0], col, row, run_attr, 8'd0);
      if (run_len != sldre_pkg::RunCountMax) run_len++;
      screen_img[base + col] = want;
      if (at_end) close_run(row);
    end
    if (expected_q.size() > n0) expected_q[expected_q.size() - 1].last = 1'b1;
  endfunction

  // ---------------- stimulus ----------------
  // tvalid is only lowered in the step of an accept or before a wait, so it
  // never gets two updates in one step
  task automatic send_item(input logic op, input logic [5:0] row, input logic [6:0] col,
                           input logic [15:0] want, input logic [15:0] ahead);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {3'b000, ahead, want, col, row};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_item(op, row, col, want, ahead);
    items_sent++;
    if (op == sldre_pkg::OpClear) clears_sent++;
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_line_width(input logic [7:0] value);
    wait_drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cfg_width = value;
  endtask

  task automatic test_directed_cells();
    // reset width is 80: column 79 ends the row, column 80 is ignored
    send_item(sldre_pkg::OpCompare, 6'd30, 7'd79, 16'h1141, 16'h0000);
    send_item(sldre_pkg::OpCompare, 6'd30, 7'd80, 16'h1142, 16'h0000);
    write_line_width(8'd16);
    send_item(sldre_pkg::OpCompare, 6'd0, 7'd0, sldre_pkg::BlankCell, sldre_pkg::BlankCell);
    send_item(sldre_pkg::OpCompare, 6'd0, 7'd1, 16'h0041, sldre_pkg::BlankCell);
    // unchanged blank bridged, next cell differs
    send_item(sldre_pkg::OpCompare, 6'd0, 7'd2, sldre_pkg::BlankCell, 16'h0042);
    send_item(sldre_pkg::OpCompare, 6'd0, 7'd3, 16'h0042, sldre_pkg::BlankCell);
    send_item(sldre_pkg::OpCompare, 6'd0, 7'd4, sldre_pkg::BlankCell, sldre_pkg::BlankCell);
    // mode change inside a run
    send_item(sldre_pkg::OpCompare, 6'd0, 7'd5, 16'h0243, 16'h0344);
    send_item(sldre_pkg::OpCompare, 6'd0, 7'd6, 16'h0344, sldre_pkg::BlankCell);
    send_item(sldre_pkg::OpCompare, 6'd0, 7'd7, sldre_pkg::BlankCell, sldre_pkg::BlankCell);
    send_item(sldre_pkg::OpCompare, 6'd0, 7'd15, 16'hFFFF, 16'h1234);
    send_item(sldre_pkg::OpCompare, 6'd0, 7'd16, 16'h5555, 16'h0000);
    send_item(sldre_pkg::OpCompare, 6'd0, 7'd127, 16'hAAAA, 16'hFFFF);
    // stale run dropped at column 0
    send_item(sldre_pkg::OpCompare, 6'd1, 7'd3, 16'h0755, sldre_pkg::BlankCell);
    send_item(sldre_pkg::OpCompare, 6'd1, 7'd0, sldre_pkg::BlankCell, sldre_pkg::BlankCell);
    send_item(sldre_pkg::OpCompare, 6'd1, 7'd1, sldre_pkg::BlankCell, sldre_pkg::BlankCell);
    // row changes mid run, end carries the new row
    send_item(sldre_pkg::OpCompare, 6'd2, 7'd4, 16'h0961, sldre_pkg::BlankCell);
    send_item(sldre_pkg::OpCompare, 6'd5, 7'd2, 16'h0962, sldre_pkg::BlankCell);
    send_item(sldre_pkg::OpCompare, 6'd5, 7'd9, sldre_pkg::BlankCell, sldre_pkg::BlankCell);
    send_item(sldre_pkg::OpCompare, 6'd63, 7'd15, 16'h0000, 16'hFFFF);
    send_item(sldre_pkg::OpClear, 6'd63, 7'd127, 16'hFFFF, 16'hFFFF);
    send_item(sldre_pkg::OpCompare, 6'd0, 7'd1, 16'h0041, sldre_pkg::BlankCell);
    write_line_width(8'd128);
    send_item(sldre_pkg::OpCompare, 6'd63, 7'd127, 16'hFFFF, 16'h0000);
    write_line_width(8'd1);
    send_item(sldre_pkg::OpCompare, 6'd0, 7'd0, 16'h8001, 16'hFFFF);
    write_line_width(8'd255);
    send_item(sldre_pkg::OpCompare, 6'd62, 7'd127, 16'h2233, sldre_pkg::BlankCell);
  endtask

  // one column rewritten over and over keeps the run open past 255 chars
  task automatic test_long_run();
    write_line_width(8'd128);
    for (int i = 0; i < 256; i++)
      send_item(sldre_pkg::OpCompare, 6'd10, 7'd5, {8'h05, 8'(i)}, sldre_pkg::BlankCell);
    send_item(sldre_pkg::OpCompare, 6'd10, 7'd6, sldre_pkg::BlankCell, sldre_pkg::BlankCell);
  endtask

  task automatic test_backpressure();
    write_line_width(8'd4);
    hold_req = 1'b1;
    for (int r = 20; r < 22; r++)
      for (int c = 0; c < 4; c++)
        send_item(sldre_pkg::OpCompare, 6'(r), 7'(c), {8'(c + 1), 8'(r + c)},
                  {8'(c + 2), 8'h30});
  endtask

  function automatic logic [15:0] make_cell(input logic [5:0] row, input int col);
    logic [15:0] cur;
    int          pick;
    cur  = (col < Cols) ? screen_img[int'(row) * Cols + col] : sldre_pkg::BlankCell;
    pick = $urandom_range(0, 99);
    if (pick < 45) return cur;
    if (pick < 60) return sldre_pkg::BlankCell;
    if (pick < 90) begin
      case ($urandom_range(0, 3))
        0: return {8'h00, 8'($urandom_range(32, 126))};
        1: return {8'h01, 8'($urandom_range(32, 126))};
        2: return {8'h07, 8'($urandom_range(32, 126))};
        default: return {8'hFF, 8'($urandom_range(32, 126))};
      endcase
    end
    return 16'($urandom);
  endfunction

  task automatic run_row_scans(input logic [7:0] width_val, input int budget);
    int          w;
    int          sent;
    logic [5:0]  row;
    logic [15:0] scan [0:Cols];
    write_line_width(width_val);
    w    = (width_val > Cols) ? Cols : int'(width_val);
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 99) < 85) begin
        row = ($urandom_range(0, 2) == 0) ? 6'($urandom_range(0, 63))
                                          : 6'($urandom_range(0, 3));
        for (int c = 0; c <= w; c++) scan[c] = make_cell(row, c);
        for (int c = 0; c < w; c++)
          send_item(sldre_pkg::OpCompare, row, 7'(c), scan[c], scan[c + 1]);
        sent += w;
      end else begin
        // noise: stray columns, random lookahead, the odd clear
        send_item(($urandom_range(0, 29) == 0) ? sldre_pkg::OpClear : sldre_pkg::OpCompare,
                  6'($urandom_range(0, 63)),
                  ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                              : 7'($urandom_range(0, w - 1)),
                  16'($urandom), 16'($urandom));
        sent++;
      end
    end
  endtask

  // ---------------- receiver ----------------
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCyc;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 15) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    sldre_pkg::res_t want_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d", m_axis_tuser));
      end else begin
        want_r = expected_q.pop_front();
        if (m_axis_tuser != want_r.kind)
          report_mismatch($sformatf("kind %0d want %0d", m_axis_tuser, want_r.kind));
        if (m_axis_tdata[7:0] != want_r.char_code)
          report_mismatch($sformatf("char %h want %h", m_axis_tdata[7:0], want_r.char_code));
        if (m_axis_tdata[14:8] != want_r.position)
          report_mismatch($sformatf("position %0d want %0d", m_axis_tdata[14:8],
                                    want_r.position));
        if (m_axis_tdata[20:15] != want_r.out_row)
          report_mismatch($sformatf("row %0d want %0d", m_axis_tdata[20:15], want_r.out_row));
        if (m_axis_tdata[28:21] != want_r.run_mode)
          report_mismatch($sformatf("mode %h want %h", m_axis_tdata[28:21], want_r.run_mode));
        if (m_axis_tdata[36:29] != want_r.run_length)
          report_mismatch($sformatf("length %0d want %0d", m_axis_tdata[36:29],
                                    want_r.run_length));
        if (m_axis_tlast != want_r.last)
          report_mismatch($sformatf("tlast %0d want %0d", m_axis_tlast, want_r.last));
      end
      results_seen++;
    end
  end

  // covers the reset and clear sweeps plus the long stall
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QuietLimit) begin
      $display("watchdog: no item moved for %0d cycles, %0d results pending", quiet,
               expected_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = 8'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = sldre_pkg::OpCompare;
    m_axis_tready = 1'b0;
    idle_on       = 1'b0;
    hold_req      = 1'b0;
    hold_left     = 0;
    stall_left    = 0;
    errors        = 0;
    items_sent    = 0;
    clears_sent   = 0;
    results_seen  = 0;
    quiet         = 0;
    blank_screen();
    run_active = 1'b0;
    run_start  = '0;
    run_attr   = '0;
    run_len    = '0;
    cfg_width  = sldre_pkg::LineWidthReset;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // image is blanked after reset before input opens
    do @(posedge clk_i); while (!s_axis_tready);
    idle_on = 1'b1;
    test_directed_cells();
    test_long_run();
    test_backpressure();
    run_row_scans(8'd12, 12);
    run_row_scans(8'd3, 6);
    idle_on = 1'b0;
    run_row_scans(8'd7, 7);
    wait_drain();
    $display("Covered %0d items (%0d clears) and %0d results, line widths 1 to 255,",
             items_sent, clears_sent, results_seen);
    $display("with blank bridging, mode splits, count saturation and output stalls.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
